// File: src/millisecond_rtc_with_rf_trigger_core_macros.svh
// ----------------------------------------------------------------------------
// millisecond rtc assertion macros
// shared concurrent assertion forms for the rtc core
// ----------------------------------------------------------------------------
`ifndef MILLISECOND_RTC_WITH_RF_TRIGGER_CORE_MACROS_SVH
`define MILLISECOND_RTC_WITH_RF_TRIGGER_CORE_MACROS_SVH

// same-cycle implication
`define MRTC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MRTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/mrtc_pkg.sv
// ----------------------------------------------------------------------------
// mrtc_pkg
// types and constants shared by the millisecond rtc core
// ----------------------------------------------------------------------------
`default_nettype none

package mrtc_pkg;

   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 120;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 20;

   localparam logic [CSR_ADDR_W-1:0] CSR_TICK_NS     = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_TRIG_RELOAD = 1'd1;

   localparam logic [19:0] TICK_NS_RESET     = 20'd37;
   localparam logic [7:0]  TRIG_RELOAD_RESET = 8'd1;

   localparam logic [9:0]  MS_MAX    = 10'd999;
   localparam logic [36:0] NS_PER_MS = 37'd1000000;
   localparam logic [36:0] NS_MAX    = 37'd999999999;

   // floor(x / 1e6) = floor((x >> 6) * RECIP >> 38) for any 30-bit x
   localparam logic [48:0] DIV_RECIP = 49'd17592187;

   typedef enum logic [2:0] {
      OP_TICK      = 3'd0,
      OP_CH1_EVENT = 3'd1,
      OP_SET_TIME  = 3'd2,
      OP_GET_TIME  = 3'd3,
      OP_ARM_CAPT  = 3'd4,
      OP_ARM_TRIG  = 3'd5,
      OP_LOAD_CD   = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_CAPTURE = 2'd1,
      MODE_TRIGGER = 2'd2
   } mode_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] set_seconds;
      logic [29:0] set_nanoseconds;
      logic [15:0] fine_count;
      logic [15:0] countdown_load;
   } req_type;

   typedef struct packed {
      logic [31:0] seconds;
      logic [9:0]  millis;
      logic [31:0] uptime;
      logic [15:0] countdown;
      logic        time_valid;
      logic        strobe;
      mode_type    mode;
      logic        is_get;
      logic [35:0] fine_ns;
   } snap_type;

endpackage

`default_nettype wire

// File: src/mrtc_update.sv
// ----------------------------------------------------------------------------
// mrtc_update
// clock state registers, opcode decode and per-beat snapshot register
// ----------------------------------------------------------------------------
`default_nettype none

module mrtc_update import mrtc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        en,
   input  wire req_type     item,
   input  wire logic [19:0] tick_ns,
   input  wire logic [7:0]  trig_reload,
   output snap_type         snap
);

   logic [9:0]  millis_ff, millis_in;
   logic [31:0] secs_ff, secs_in;
   logic [31:0] uptime_ff, uptime_in;
   logic [15:0] countdown_ff, countdown_in;
   logic        time_set_ff, time_set_in;
   mode_type    mode_ff, mode_in;
   logic [7:0]  delay_ff, delay_in;
   logic        strobe;
   snap_type    snap_ff, snap_in;

   logic [48:0] div_prod;
   logic [10:0] div_q;
   logic [9:0]  set_ms;

   assign div_prod = {25'd0, item.set_nanoseconds[29:6]} * DIV_RECIP;
   assign div_q    = div_prod[48:38];
   assign set_ms   = (div_q > {1'b0, MS_MAX}) ? MS_MAX : div_q[9:0];

   always_comb begin
      millis_in    = millis_ff;
      secs_in      = secs_ff;
      uptime_in    = uptime_ff;
      countdown_in = countdown_ff;
      time_set_in  = time_set_ff;
      mode_in      = mode_ff;
      delay_in     = delay_ff;
      strobe       = 1'b0;
      if (en) begin
         unique case (item.op)
            OP_TICK: begin
               if (countdown_ff != 16'd0) begin
                  countdown_in = countdown_ff - 16'd1;
               end
               if (millis_ff >= MS_MAX) begin
                  millis_in = 10'd0;
                  secs_in   = secs_ff + 32'd1;
                  uptime_in = uptime_ff + 32'd1;
               end else begin
                  millis_in = millis_ff + 10'd1;
               end
            end
            OP_CH1_EVENT: begin
               if (mode_ff == MODE_CAPTURE) begin
                  mode_in = MODE_IDLE;
               end else if (mode_ff == MODE_TRIGGER) begin
                  delay_in = delay_ff - 8'd1;
                  if (delay_ff == 8'd1) begin
                     strobe  = 1'b1;
                     mode_in = MODE_IDLE;
                  end
               end
            end
            OP_SET_TIME: begin
               millis_in   = set_ms;
               secs_in     = item.set_seconds;
               time_set_in = 1'b1;
            end
            OP_ARM_CAPT: begin
               mode_in = MODE_CAPTURE;
            end
            OP_ARM_TRIG: begin
               delay_in = trig_reload;
               mode_in  = MODE_TRIGGER;
            end
            OP_LOAD_CD: begin
               countdown_in = item.countdown_load;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      snap_in.seconds    = secs_in;
      snap_in.millis     = millis_in;
      snap_in.uptime     = uptime_in;
      snap_in.countdown  = countdown_in;
      snap_in.time_valid = time_set_in;
      snap_in.strobe     = strobe;
      snap_in.mode       = mode_in;
      snap_in.is_get     = (item.op == OP_GET_TIME);
      snap_in.fine_ns    = {20'd0, item.fine_count} * {16'd0, tick_ns};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         millis_ff    <= '0;
         secs_ff      <= '0;
         uptime_ff    <= '0;
         countdown_ff <= '0;
         time_set_ff  <= 1'b0;
         mode_ff      <= MODE_IDLE;
         delay_ff     <= '0;
      end else begin
         millis_ff    <= millis_in;
         secs_ff      <= secs_in;
         uptime_ff    <= uptime_in;
         countdown_ff <= countdown_in;
         time_set_ff  <= time_set_in;
         mode_ff      <= mode_in;
         delay_ff     <= delay_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         snap_ff <= snap_in;
      end
   end

   assign snap = snap_ff;

endmodule

`default_nettype wire

// File: src/mrtc_result.sv
// ----------------------------------------------------------------------------
// mrtc_result
// sub-second time assembly, saturation and result output register
// ----------------------------------------------------------------------------
`default_nettype none

module mrtc_result import mrtc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  adv,
   input  wire logic                  snap_valid,
   input  wire snap_type              snap,
   output logic                       rsp_valid,
   output logic [RSP_DATA_W-1:0]      rsp_data
);

   logic [36:0]           ms_ns;
   logic [36:0]           sum_ns;
   logic [29:0]           ns_out;
   logic                  valid_ff, valid_in;
   logic [RSP_DATA_W-1:0] data_ff, data_in;

   assign ms_ns  = {27'd0, snap.millis} * NS_PER_MS;
   assign sum_ns = ms_ns + (snap.is_get ? {1'b0, snap.fine_ns} : 37'd0);
   assign ns_out = (sum_ns > NS_MAX) ? NS_MAX[29:0] : sum_ns[29:0];

   assign valid_in = adv ? snap_valid : valid_ff;
   assign data_in  = {5'd0, snap.mode, snap.strobe, snap.time_valid,
                      (snap.countdown == 16'd0), snap.countdown, snap.uptime,
                      ns_out, snap.seconds};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

// File: src/millisecond_rtc_with_rf_trigger_core.sv
// ----------------------------------------------------------------------------
// millisecond_rtc_with_rf_trigger_core
// millisecond real-time clock with countdown and channel-one trigger
//
//   port group  dir  beat contents
//   req_*       in   opcode in tuser, set/fine/load values in tdata
//   rsp_*       out  one result beat per request beat
//   csr_*       in   register write, index 0 tick_ns, 1 trigger reload
//
// one beat per cycle sustained while the result is not stalled; a request beat passes through the
// input register, state update stage and result output register
// a stalled result holds all three stages; req_tready drops with it
// synchronous reset clears state, mode and pipeline valids, loads csr defaults
// ----------------------------------------------------------------------------
`default_nettype none

`include "millisecond_rtc_with_rf_trigger_core_macros.svh"

module millisecond_rtc_with_rf_trigger_core import mrtc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // opcode[2:0]
   input  wire logic [7:0]            req_tuser,
   // set_seconds[31:0], set_nanoseconds[61:32], fine_count[77:62],
   // countdown_load[93:78], zero pad
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // seconds_out[31:0], nanoseconds_out[61:32], uptime_out[93:62],
   // countdown_out[109:94], countdown_done[110], time_valid[111],
   // transmit_strobe[112], channel_mode[114:113], zero pad
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   logic        adv;
   logic        s1_valid_ff, s1_valid_in;
   req_type     s1_item_ff, s1_item_in;
   logic        s2_valid_ff, s2_valid_in;
   snap_type    snap;
   logic [19:0] tick_ns_ff, tick_ns_in;
   logic [7:0]  reload_ff, reload_in;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   always_comb begin
      tick_ns_in = tick_ns_ff;
      reload_in  = reload_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_TICK_NS:     tick_ns_in = csr_wdata;
            CSR_TRIG_RELOAD: reload_in  = csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   assign s1_valid_in = adv ? req_tvalid : s1_valid_ff;
   assign s2_valid_in = adv ? s1_valid_ff : s2_valid_ff;

   always_comb begin
      s1_item_in.op              = op_type'(req_tuser[2:0]);
      s1_item_in.set_seconds     = req_tdata[31:0];
      s1_item_in.set_nanoseconds = req_tdata[61:32];
      s1_item_in.fine_count      = req_tdata[77:62];
      s1_item_in.countdown_load  = req_tdata[93:78];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         tick_ns_ff  <= TICK_NS_RESET;
         reload_ff   <= TRIG_RELOAD_RESET;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         tick_ns_ff  <= tick_ns_in;
         reload_ff   <= reload_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_item_ff <= s1_item_in;
      end
   end

   mrtc_update u_update (
      .clock       (clock),
      .reset       (reset),
      .en          (adv && s1_valid_ff),
      .item        (s1_item_ff),
      .tick_ns     (tick_ns_ff),
      .trig_reload (reload_ff),
      .snap        (snap)
   );

   mrtc_result u_result (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .snap_valid (s2_valid_ff),
      .snap       (snap),
      .rsp_valid  (rsp_tvalid),
      .rsp_data   (rsp_tdata)
   );

   `MRTC_ASSERT_IMPLY(a_stall_blocks_req, clock, reset, rsp_tvalid && !rsp_tready, !req_tready, "request taken while result stalled")
   `MRTC_ASSERT_IMPLY(a_strobe_idles, clock, reset, rsp_tvalid && rsp_tdata[112], rsp_tdata[114:113] == MODE_IDLE, "strobe without return to idle")
   `MRTC_ASSERT_IMPLY(a_ns_saturated, clock, reset, rsp_tvalid, {7'd0, rsp_tdata[61:32]} <= NS_MAX, "nanoseconds above one second")
   `MRTC_ASSERT_NEXT(a_stage_hold, clock, reset, s2_valid_ff && !adv, s2_valid_ff && rsp_tvalid, "pipeline lost a beat under stall")

endmodule

`default_nettype wire
